/* rtl/core/brd_pkg.sv */
// Shared types and constants for the boxcar rate decimator.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none
package brd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 18;
  localparam int WIN_W      = 21;
  localparam int CNT_W      = 5;
  localparam int MAX_WINDOW = 24;

  localparam logic [RATE_W:0] OUT_RATE_LOW  = 19'd8000;
  localparam logic [RATE_W:0] OUT_RATE_HIGH = 19'd16000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Register indexes on the configuration port (byte address 4*index).
  localparam int PADDR_W = 3;
  localparam logic REG_INPUT_RATE = 1'b0;
  localparam logic REG_OUT_SEL    = 1'b1;

  // Input action codes.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Queue between the window tracker and the divider.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One quotient bit per divider step.
  localparam int DIV_STEPS = WIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [RATE_W-1:0] input_rate;
    logic              out_sel;
  } brd_cfg_t;

  typedef struct packed {
    logic signed [WIN_W-1:0] total;
    logic [CNT_W-1:0]        count;
  } brd_win_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } brd_div_state_t;

endpackage : brd_pkg
`default_nettype wire

/* rtl/core/brd_front.sv */
// Front end: accepts words, advances the phase accumulator and the window sum,
// and queues a finished window for division. Depends on brd_pkg.
`default_nettype none
module brd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire brd_pkg::brd_cfg_t             cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_action,
  input  wire logic signed [15:0]            in_sample,
  input  wire logic                          q_full,
  output logic                               q_push,
  output brd_pkg::brd_win_t                  q_data
);
  import brd_pkg::*;

  logic [RATE_W-1:0]       phase_r, phase_nxt;
  logic signed [WIN_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic              accept;
  logic [RATE_W:0]   step;
  logic [RATE_W:0]   rate_ext;
  logic [RATE_W:0]   sum;
  logic [RATE_W:0]   wrapped;
  logic              emits;
  logic              full_win;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    step      = cfg.out_sel ? OUT_RATE_HIGH : OUT_RATE_LOW;
    rate_ext  = {1'b0, cfg.input_rate};
    sum       = {1'b0, phase_r} + step;
    emits     = (sum >= rate_ext);
    wrapped   = sum - rate_ext;
    total_nxt = total_r + WIN_W'(in_sample);
    count_nxt = count_r + CNT_W'(1);
    full_win  = (count_nxt >= CNT_W'(MAX_WINDOW));
    if (emits) begin
      // A phase still past the rate after one wrap restarts from zero.
      phase_nxt = (wrapped >= rate_ext) ? '0 : wrapped[RATE_W-1:0];
    end else begin
      phase_nxt = sum[RATE_W-1:0];
    end
  end

  assign q_push       = accept && (in_action == ACT_SAMPLE) && (emits || full_win);
  assign q_data.total = total_nxt;
  assign q_data.count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      total_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      if (in_action == ACT_CLEAR) begin
        phase_r <= '0;
        total_r <= '0;
        count_r <= '0;
      end else begin
        phase_r <= phase_nxt;
        if (emits || full_win) begin
          total_r <= '0;
          count_r <= '0;
        end else begin
          total_r <= total_nxt;
          count_r <= count_nxt;
        end
      end
    end
  end

endmodule : brd_front
`default_nettype wire

/* rtl/core/brd_fifo.sv */
// Short queue of finished windows between the front end and the divider.
// Depends on brd_pkg.
`default_nettype none
module brd_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire brd_pkg::brd_win_t  push_data,
  output logic                    full,
  input  wire logic               pop,
  output brd_pkg::brd_win_t       pop_data,
  output logic                    empty
);
  import brd_pkg::*;

  brd_win_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    fill_r;

  assign full     = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill_r <= fill_r + (QPTR_W+1)'(1);
        2'b01:   fill_r <= fill_r - (QPTR_W+1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule : brd_fifo
`default_nettype wire

/* rtl/core/brd_divider.sv */
// Back end: restoring divider, one quotient bit per cycle, then sign fix,
// saturation and the output register. Depends on brd_pkg.
`default_nettype none
module brd_divider (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire brd_pkg::brd_win_t   q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       out_sample
);
  import brd_pkg::*;

  brd_div_state_t state_r, state_nxt;

  logic                   neg_r;
  logic [WIN_W-1:0]       dvd_r;
  logic [CNT_W-1:0]       rem_r;
  logic [CNT_W-1:0]       div_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   out_valid_r;
  logic signed [15:0]     out_sample_r;

  logic                   load_out;
  logic                   last_step;
  logic [CNT_W:0]         shifted;
  logic                   ge;
  logic [CNT_W:0]         diff;
  logic [WIN_W-1:0]       mag;
  logic signed [WIN_W:0]  signed_q;
  logic signed [15:0]     sat_q;

  assign last_step = (cnt_r == DIV_CNT_W'(DIV_STEPS-1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: if (!q_empty) state_nxt = DIV_RUN;
      DIV_RUN:  if (last_step) state_nxt = DIV_DONE;
      DIV_DONE: if (!out_valid_r || out_ready) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      DIV_IDLE: q_pop = !q_empty;
      DIV_RUN:  ;
      DIV_DONE: load_out = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  always_comb begin
    shifted  = {rem_r, dvd_r[WIN_W-1]};
    diff     = shifted - {1'b0, div_r};
    ge       = (shifted >= {1'b0, div_r});
    mag      = q_data.total[WIN_W-1] ? WIN_W'(-q_data.total) : WIN_W'(q_data.total);
    signed_q = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
    if (signed_q > (WIN_W+1)'(SAMPLE_MAX)) begin
      sat_q = SAMPLE_MAX;
    end else if (signed_q < (WIN_W+1)'(SAMPLE_MIN)) begin
      sat_q = SAMPLE_MIN;
    end else begin
      sat_q = signed_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DIV_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg_r <= q_data.total[WIN_W-1];
      dvd_r <= mag;
      div_r <= q_data.count;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (state_r == DIV_RUN) begin
      dvd_r <= {dvd_r[WIN_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
    if (load_out) begin
      out_sample_r <= sat_q;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule : brd_divider
`default_nettype wire

/* rtl/core/boxcar_rate_decimator.sv */
// Boxcar rate decimator, top level. An emitting input word passes through
// the front end, a queue hand-off, 21 steps of the one-bit-per-cycle
// restoring divider and the output register. Input words are taken one per
// cycle until the two-entry queue fills; the divider works on one window at
// a time and takes the next only after it has registered the last result.
// Synchronous active-low reset clears phase, window, queue and output valid.
`default_nettype none
module boxcar_rate_decimator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Configuration port, APB style, always ready.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [brd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // Input words.
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_action,
  input  wire logic signed [15:0]          in_sample,
  // Output words.
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [15:0]               out_sample
);
  import brd_pkg::*;

  // Registers sit at byte address 4*index, so bit 2 of the address picks
  // the register and the byte lane bits are ignored.
  brd_cfg_t cfg_r;
  logic     cfg_wr;
  logic     reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_rate <= RATE_W'(48000);
      cfg_r.out_sel    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_index)
        REG_INPUT_RATE: cfg_r.input_rate <= pwdata[RATE_W-1:0];
        REG_OUT_SEL:    cfg_r.out_sel    <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_INPUT_RATE: prdata = {{(32-RATE_W){1'b0}}, cfg_r.input_rate};
      REG_OUT_SEL:    prdata = {31'd0, cfg_r.out_sel};
      default:        prdata = '0;
    endcase
  end

  // The front end updates the window state in the cycle a word is taken and
  // queues each finished window; it stalls only when the queue is full.
  logic     q_push, q_full, q_pop, q_empty;
  brd_win_t q_push_data, q_pop_data;

  brd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  brd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // The back end divides the window sum by its count, truncating toward
  // zero, saturates to 16 bits and holds the word until it is taken.
  brd_divider u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_pop_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
  );

endmodule : boxcar_rate_decimator
`default_nettype wire
